// ===== rtl/core/zrle_pkg.sv =====
// ----------------------------------------------------------------------------
// zrle_pkg
// shared types and constants of the zero run-length encoder
// ----------------------------------------------------------------------------
package zrle_pkg;

   localparam int unsigned RunW     = 6;
   localparam int unsigned HeldW    = 3;
   localparam int unsigned BankCnt  = 2;
   localparam int unsigned BankW    = 1;
   localparam int unsigned AddrW    = BankW + RunW;
   localparam int unsigned MemDepth = BankCnt << RunW;

   localparam logic [RunW-1:0] MaxRun    = 6'h3f;
   localparam logic [RunW-1:0] MaxMerged = 6'h0f;
   localparam logic [RunW-1:0] HoldLimit = 6'd8;
   localparam logic [7:0]      ZeroTag   = 8'h40;
   localparam logic [7:0]      MergeTag  = 8'h80;

   // one run close: control byte, then lit_cnt literals from one bank
   typedef struct packed {
      logic [7:0]      ctrl;
      logic [RunW-1:0] lit_cnt;
      logic [BankW-1:0] bank;
      logic            run_last;
      logic            stream_end;
   } cmd_type;

   typedef struct packed {
      logic             we;
      logic [AddrW-1:0] addr;
      logic [7:0]       data;
   } mem_wr_type;

   typedef struct packed {
      logic             valid;
      logic [BankW-1:0] bank;
   } release_type;

endpackage

// ===== rtl/core/zrle_if.sv =====
// ----------------------------------------------------------------------------
// zrle_req_if / zrle_rsp_if
// valid/ready channels of the zero run-length encoder
// ----------------------------------------------------------------------------
interface zrle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface zrle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       is_control;
   logic       run_last;
   logic       stream_end;

   modport source (output valid, output code_byte, output is_control,
                   output run_last, output stream_end, input ready);
   modport sink   (input valid, input code_byte, input is_control,
                   input run_last, input stream_end, output ready);
endinterface

// ===== rtl/core/zero_run_length_encoder_v2_top.sv =====
// ----------------------------------------------------------------------------
// zero_run_length_encoder_v2_top
// zero run-length encoder, byte stream in, control and literal bytes out
// ----------------------------------------------------------------------------
// req_if takes one raw byte per item with last_byte marking the stream end.
// rsp_if gives encoded bytes: a control byte per run followed by the run's
// literals, short zero runs sharing the next literal run's control byte;
// run_last marks the last result caused by an input item, stream_end the
// final byte of the encoded stream. an item closing both the previous run
// and its own parks its second close in a pending register, holding
// req_if.ready low; the command queue absorbs closes while results drain.
// results leave at one per cycle while rsp_if.ready is high, through a
// registered literal store, so a run of n literals gives n + 1 results; the
// first result of a close passes through the queue and the output register.
// literals are kept in two banks; input waits while its bank still drains.
// reset is synchronous and clears run state, queue and output valid; the
// literal store needs no clearing. when rsp_if.ready is low the output
// register holds, the queue fills and req_if.ready drops.
// ----------------------------------------------------------------------------
module zero_run_length_encoder_v2_top import zrle_pkg::*; #(
   parameter int unsigned QueueDepth = 4
) (
   input  logic       clock,
   input  logic       reset,
   zrle_req_if.sink   req_if,
   zrle_rsp_if.source rsp_if
);

   logic        push_valid, fifo_full, fifo_empty, pop;
   cmd_type     push_cmd, head;
   mem_wr_type  mem_wr;
   release_type rel;

   zrle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .fifo_full  (fifo_full),
      .mem_wr     (mem_wr),
      .rel        (rel)
   );

   zrle_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_cmd (push_cmd),
      .full     (fifo_full),
      .pop      (pop),
      .head     (head),
      .empty    (fifo_empty)
   );

   zrle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .mem_wr     (mem_wr),
      .head       (head),
      .fifo_empty (fifo_empty),
      .pop        (pop),
      .rel        (rel),
      .rsp_if     (rsp_if)
   );

endmodule

// ===== rtl/core/zrle_front.sv =====
// ----------------------------------------------------------------------------
// zrle_front
// accepts bytes, tracks the open run and issues run-close commands
// ----------------------------------------------------------------------------
module zrle_front import zrle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   zrle_req_if.sink    req_if,
   output logic        push_valid,
   output cmd_type     push_cmd,
   input  logic        fifo_full,
   output mem_wr_type  mem_wr,
   input  release_type rel
);

   logic              act_ff, act_in;
   logic              rz_ff, rz_in;
   logic [RunW-1:0]   rlen_ff, rlen_in;
   logic [HeldW-1:0]  held_ff, held_in;
   logic [BankW-1:0]  wbank_ff, wbank_in;
   logic [BankCnt-1:0] busy_ff, busy_in;
   logic              pend_valid_ff, pend_valid_in;
   cmd_type           pend_cmd_ff, pend_cmd_in;

   logic              accept, z, last;
   logic              close_a, a_emit, close_b, full, toggle;
   logic [HeldW-1:0]  held_a;
   logic [RunW-1:0]   len0, len1;
   cmd_type           a_cmd, b_cmd;

   assign req_if.ready = !pend_valid_ff && !fifo_full && !busy_ff[wbank_ff];
   assign accept       = req_if.valid && req_if.ready;
   assign z            = (req_if.data_byte == 8'h00);
   assign last         = req_if.last_byte;

   always_comb begin
      // close of the previous run on a zero/literal switch
      close_a          = act_ff && (z != rz_ff);
      a_emit           = 1'b0;
      held_a           = held_ff;
      a_cmd.ctrl       = ZeroTag | {2'b00, rlen_ff};
      a_cmd.lit_cnt    = '0;
      a_cmd.bank       = wbank_ff;
      a_cmd.run_last   = 1'b0;
      a_cmd.stream_end = 1'b0;
      if (close_a) begin
         if (rz_ff) begin
            a_emit = (rlen_ff >= HoldLimit);
            if (!a_emit) begin
               held_a = rlen_ff[HeldW-1:0];
            end
         end else begin
            a_emit        = 1'b1;
            a_cmd.lit_cnt = rlen_ff;
            held_a        = '0;
            if (held_ff != '0) begin
               a_cmd.ctrl = MergeTag | {1'b0, held_ff, rlen_ff[3:0]};
            end else begin
               a_cmd.ctrl = {2'b00, rlen_ff};
            end
         end
      end

      // current run after this byte
      len0    = (act_ff && !close_a) ? rlen_ff : '0;
      len1    = len0 + 1'b1;
      full    = (len1 == MaxRun) || (!z && (held_a != '0) && (len1 >= MaxMerged));
      close_b = full || last;

      b_cmd.bank       = wbank_ff;
      b_cmd.run_last   = 1'b1;
      b_cmd.stream_end = last;
      if (z) begin
         b_cmd.ctrl    = ZeroTag | {2'b00, len1};
         b_cmd.lit_cnt = '0;
      end else begin
         b_cmd.lit_cnt = len1;
         if (held_a != '0) begin
            b_cmd.ctrl = MergeTag | {1'b0, held_a, len1[3:0]};
         end else begin
            b_cmd.ctrl = {2'b00, len1};
         end
      end
      a_cmd.run_last = !close_b;

      toggle = (close_a && !rz_ff) || (close_b && !z);
   end

   always_comb begin
      act_in        = act_ff;
      rz_in         = rz_ff;
      rlen_in       = rlen_ff;
      held_in       = held_ff;
      wbank_in      = wbank_ff;
      busy_in       = busy_ff;
      pend_valid_in = pend_valid_ff;
      pend_cmd_in   = pend_cmd_ff;
      push_valid    = 1'b0;
      push_cmd      = pend_cmd_ff;

      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end

      if (pend_valid_ff) begin
         if (!fifo_full) begin
            push_valid    = 1'b1;
            pend_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (close_a && a_emit) begin
            push_valid    = 1'b1;
            push_cmd      = a_cmd;
            pend_valid_in = close_b;
            pend_cmd_in   = b_cmd;
         end else if (close_b) begin
            push_valid = 1'b1;
            push_cmd   = b_cmd;
         end

         rz_in = z;
         if (close_b) begin
            act_in  = 1'b0;
            rlen_in = '0;
         end else begin
            act_in  = 1'b1;
            rlen_in = len1;
         end
         if (last || (close_b && !z)) begin
            held_in = '0;
         end else begin
            held_in = held_a;
         end
         if (toggle) begin
            wbank_in          = ~wbank_ff;
            busy_in[wbank_ff] = 1'b1;
         end
      end
   end

   assign mem_wr.we   = accept && !z;
   assign mem_wr.addr = {wbank_ff, len0};
   assign mem_wr.data = req_if.data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff        <= 1'b0;
         rz_ff         <= 1'b0;
         rlen_ff       <= '0;
         held_ff       <= '0;
         wbank_ff      <= '0;
         busy_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         act_ff        <= act_in;
         rz_ff         <= rz_in;
         rlen_ff       <= rlen_in;
         held_ff       <= held_in;
         wbank_ff      <= wbank_in;
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_cmd_ff <= pend_cmd_in;
   end

endmodule

// ===== rtl/core/zrle_fifo.sv =====
// ----------------------------------------------------------------------------
// zrle_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module zrle_fifo import zrle_pkg::*; #(
   parameter int unsigned Depth = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   cmd_type         slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == CntW'(Depth));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/zrle_back.sv =====
// ----------------------------------------------------------------------------
// zrle_back
// literal store and result sequencer: control byte, then buffered literals
// ----------------------------------------------------------------------------
module zrle_back import zrle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mem_wr_type  mem_wr,
   input  cmd_type     head,
   input  logic        fifo_empty,
   output logic        pop,
   output release_type rel,
   zrle_rsp_if.source  rsp_if
);

   logic [7:0]       lit_mem [MemDepth];
   logic [7:0]       rd_data_ff;

   logic             cur_busy_ff, cur_busy_in;
   logic [BankW-1:0] cur_bank_ff, cur_bank_in;
   logic [RunW-1:0]  cur_idx_ff, cur_idx_in;
   logic [RunW-1:0]  cur_left_ff, cur_left_in;
   logic             cur_rl_ff, cur_rl_in;
   logic             cur_se_ff, cur_se_in;

   logic             out_valid_ff, out_valid_in;
   logic             out_lit_ff, out_lit_in;
   logic [7:0]       out_ctrl_ff, out_ctrl_in;
   logic             out_rl_ff, out_rl_in;
   logic             out_se_ff, out_se_in;

   logic             out_free, issue_lit, issue_ctl;
   logic [AddrW-1:0] rd_addr;

   assign out_free  = !out_valid_ff || rsp_if.ready;
   assign issue_lit = cur_busy_ff && out_free;
   assign issue_ctl = !cur_busy_ff && !fifo_empty && out_free;
   assign pop       = issue_ctl;
   assign rd_addr   = {cur_bank_ff, cur_idx_ff};

   always_comb begin
      cur_busy_in  = cur_busy_ff;
      cur_bank_in  = cur_bank_ff;
      cur_idx_in   = cur_idx_ff;
      cur_left_in  = cur_left_ff;
      cur_rl_in    = cur_rl_ff;
      cur_se_in    = cur_se_ff;
      out_valid_in = out_valid_ff;
      out_lit_in   = out_lit_ff;
      out_ctrl_in  = out_ctrl_ff;
      out_rl_in    = out_rl_ff;
      out_se_in    = out_se_ff;
      rel.valid    = 1'b0;
      rel.bank     = cur_bank_ff;

      if (issue_ctl) begin
         out_valid_in = 1'b1;
         out_lit_in   = 1'b0;
         out_ctrl_in  = head.ctrl;
         out_rl_in    = head.run_last && (head.lit_cnt == '0);
         out_se_in    = head.stream_end && (head.lit_cnt == '0);
         cur_busy_in  = (head.lit_cnt != '0);
         cur_bank_in  = head.bank;
         cur_idx_in   = '0;
         cur_left_in  = head.lit_cnt;
         cur_rl_in    = head.run_last;
         cur_se_in    = head.stream_end;
      end else if (issue_lit) begin
         out_valid_in = 1'b1;
         out_lit_in   = 1'b1;
         out_rl_in    = cur_rl_ff && (cur_left_ff == 6'd1);
         out_se_in    = cur_se_ff && (cur_left_ff == 6'd1);
         cur_idx_in   = cur_idx_ff + 1'b1;
         cur_left_in  = cur_left_ff - 1'b1;
         if (cur_left_ff == 6'd1) begin
            cur_busy_in = 1'b0;
            rel.valid   = 1'b1;
         end
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_busy_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_busy_ff  <= cur_busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_bank_ff <= cur_bank_in;
      cur_idx_ff  <= cur_idx_in;
      cur_left_ff <= cur_left_in;
      cur_rl_ff   <= cur_rl_in;
      cur_se_ff   <= cur_se_in;
      out_lit_ff  <= out_lit_in;
      out_ctrl_ff <= out_ctrl_in;
      out_rl_ff   <= out_rl_in;
      out_se_ff   <= out_se_in;
   end

   // literal store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr.we) begin
         lit_mem[mem_wr.addr] <= mem_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_lit) begin
         rd_data_ff <= lit_mem[rd_addr];
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.code_byte  = out_lit_ff ? rd_data_ff : out_ctrl_ff;
   assign rsp_if.is_control = !out_lit_ff;
   assign rsp_if.run_last   = out_rl_ff;
   assign rsp_if.stream_end = out_se_ff;

endmodule
